[hw/rtl/axis_angle_point_rotator_defines.svh]
// Assertion macros for the axis-angle point rotator.
`ifndef AXIS_ANGLE_POINT_ROTATOR_DEFINES_SVH
`define AXIS_ANGLE_POINT_ROTATOR_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define AAPR_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AAPR_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

[hw/rtl/aapr_pkg.sv]
// Package: payload types and fixed-point constants of the point rotator.
`timescale 1ns / 1ps
`default_nettype none
package aapr_pkg;
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               saturated;
    } point_out_t;

    localparam int ATAN_LEN = 24;
    localparam logic signed [39:0] CORDIC_GAIN = 40'sd10188014;
    localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
    localparam logic signed [16:0] PI_Q13 = 17'sd25736;
    localparam logic signed [17:0] ONE_Q14 = 18'sd16384;
    localparam logic signed [17:0] MAT_MAX = 18'sd131071;
    localparam logic signed [17:0] MAT_MIN = -18'sd131072;

    localparam logic [1:0] REG_ANGLE  = 2'd0;
    localparam logic [1:0] REG_AXIS_X = 2'd1;
    localparam logic [1:0] REG_AXIS_Y = 2'd2;
    localparam logic [1:0] REG_AXIS_Z = 2'd3;

    function automatic logic signed [39:0] atan_val(input logic [4:0] i);
        logic signed [39:0] r;
        unique case (i)
            5'd0: r = 40'sd13176795;
            5'd1: r = 40'sd7778716;
            5'd2: r = 40'sd4110060;
            5'd3: r = 40'sd2086331;
            5'd4: r = 40'sd1047214;
            5'd5: r = 40'sd524117;
            5'd6: r = 40'sd262123;
            5'd7: r = 40'sd131069;
            default: r = (i < 5'd24) ? (40'sd1 <<< (5'd24 - i)) : 40'sd0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

[hw/rtl/axis_angle_point_rotator.sv]
// Top level: axis-angle point rotator with config port and point pipeline.
`timescale 1ns / 1ps
`default_nettype none
`include "axis_angle_point_rotator_defines.svh"
// Rotates Q24.8 points by a 3x3 Rodrigues matrix held in registers. The point
// pipeline takes one request per clock while the output is not stalled,
// through four register stages (products, pair sums, full sum, rounded and
// saturated output); a stall on the output freezes the whole pipe. After each
// register write the matrix is rebuilt by an iterative CORDIC (CORDIC_STEPS
// iterations, capped at 24) and a sequenced multiplier, and a write during a
// rebuild restarts it. Points must not be sent until the rebuild is done.
module axis_angle_point_rotator #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [3:0]            paddr,
    input  wire  [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  wire                   in_valid,
    output logic                  in_stall,
    input  wire aapr_pkg::point_in_t  in_data,
    output logic                  out_valid,
    input  wire                   out_stall,
    output aapr_pkg::point_out_t  out_data
);
    logic signed [15:0] angle_reg, ax_reg, ay_reg, az_reg;
    logic signed [17:0] mat_reg [9];
    logic wr_cfg, known;
    logic bld_busy, bld_wr;
    logic [3:0] bld_idx;
    logic signed [17:0] bld_data;

    assign pready = 1'b1;
    assign wr_cfg = psel && penable && pwrite;
    assign known  = (paddr[1:0] == 2'b00);

    always_comb
    begin
        prdata = 32'd0;
        unique case (paddr[3:2])
            aapr_pkg::REG_ANGLE:  prdata = 32'(angle_reg);
            aapr_pkg::REG_AXIS_X: prdata = 32'(ax_reg);
            aapr_pkg::REG_AXIS_Y: prdata = 32'(ay_reg);
            aapr_pkg::REG_AXIS_Z: prdata = 32'(az_reg);
            default: prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= 16'sd0;
            ax_reg <= 16'sd0;
            ay_reg <= 16'sd0;
            az_reg <= 16'sd16384;
        end
        else if (wr_cfg && known)
        begin
            unique case (paddr[3:2])
                aapr_pkg::REG_ANGLE:  angle_reg <= pwdata[15:0];
                aapr_pkg::REG_AXIS_X: ax_reg <= pwdata[15:0];
                aapr_pkg::REG_AXIS_Y: ay_reg <= pwdata[15:0];
                aapr_pkg::REG_AXIS_Z: az_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    logic start_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_reg <= 1'b0;
        else
            start_reg <= wr_cfg && known;
    end

    aapr_matrix_builder #(.CORDIC_STEPS(CORDIC_STEPS)) u_build (
        .clk(clk), .rst_n(rst_n), .start(start_reg),
        .angle(angle_reg), .ax(ax_reg), .ay(ay_reg), .az(az_reg),
        .busy(bld_busy), .wr_en(bld_wr), .wr_idx(bld_idx), .wr_data(bld_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                mat_reg[i] <= (i % 4 == 0) ? aapr_pkg::ONE_Q14 : 18'sd0;
        end
        else if (bld_wr)
            mat_reg[bld_idx] <= bld_data;
    end

    // pipeline: v1 products, v2 pair sums, v3 full sum, v4 output
    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [49:0] p_reg [9];
    logic signed [50:0] s2a_reg [3];
    logic signed [49:0] s2b_reg [3];
    logic signed [51:0] acc_reg [3];
    aapr_pkg::point_out_t out_reg, res;
    logic signed [31:0] pt [3];

    assign adv = !(v4_reg && out_stall);
    assign in_stall = !adv;
    assign pt[0] = in_data.point_x;
    assign pt[1] = in_data.point_y;
    assign pt[2] = in_data.point_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid; v2_reg <= v1_reg; v3_reg <= v2_reg; v4_reg <= v3_reg;
        end
    end

    logic signed [37:0] rnd [3];
    logic sat [3];
    logic signed [31:0] val [3];
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            rnd[r] = 38'((acc_reg[r] + 52'sd8192) >>> 14);
            sat[r] = (rnd[r] > 38'sd2147483647) || (rnd[r] < -38'sd2147483648);
            if (rnd[r] > 38'sd2147483647)
                val[r] = 32'sh7fffffff;
            else if (rnd[r] < -38'sd2147483648)
                val[r] = 32'sh80000000;
            else
                val[r] = rnd[r][31:0];
        end
        res.out_x = val[0];
        res.out_y = val[1];
        res.out_z = val[2];
        res.saturated = sat[0] || sat[1] || sat[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                    p_reg[r*3+k] <= 50'(mat_reg[r*3+k]) * 50'(pt[k]);
                s2a_reg[r] <= 51'(p_reg[r*3]) + 51'(p_reg[r*3+1]);
                s2b_reg[r] <= p_reg[r*3+2];
                acc_reg[r] <= 52'(s2a_reg[r]) + 52'(s2b_reg[r]);
            end
            out_reg <= res;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = out_reg;

    `AAPR_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && out_stall,
                      out_valid && $stable(out_data))
    `AAPR_ASSERT_IMP(a_no_stream_build, clk, rst_n, bld_busy, !v1_reg)
    `AAPR_ASSERT_IMP(a_stall_only_full, clk, rst_n, in_stall, out_valid)
endmodule
`default_nettype wire

[hw/rtl/aapr_matrix_builder.sv]
// Matrix builder: iterative CORDIC then sequenced Rodrigues terms.
`timescale 1ns / 1ps
`default_nettype none
module aapr_matrix_builder #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  wire signed [15:0] angle,
    input  wire signed [15:0] ax,
    input  wire signed [15:0] ay,
    input  wire signed [15:0] az,
    output logic              busy,
    output logic              wr_en,
    output logic [3:0]        wr_idx,
    output logic signed [17:0] wr_data
);
    localparam int STEPS = (CORDIC_STEPS > aapr_pkg::ATAN_LEN) ? aapr_pkg::ATAN_LEN
                                                                : CORDIC_STEPS;
    localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CORD = 4'b0010,
        ST_MUL1 = 4'b0100,
        ST_MUL2 = 4'b1000
    } bstate_t;

    bstate_t state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic [3:0] ent_reg, ent_next;
    logic neg_reg, neg_next;
    logic signed [39:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    // stage 1 products: omc*ai and s*ak (c*2^14 on the diagonal)
    logic signed [57:0] pa_reg, pb_reg;
    logic signed [17:0] wr_data_reg;
    logic wr_en_reg;
    logic [3:0] wr_idx_reg;

    logic signed [16:0] ang_red;
    logic signed [39:0] c, s, omc;
    logic signed [15:0] ai, aj, ak;
    logic               sgn;
    logic               diag;

    always_comb
    begin
        ang_red = 17'(angle);
        if (angle > aapr_pkg::HALF_PI_Q13)
            ang_red = 17'(angle) - aapr_pkg::PI_Q13;
        else if (angle < -aapr_pkg::HALF_PI_Q13)
            ang_red = 17'(angle) + aapr_pkg::PI_Q13;
    end

    assign c   = neg_reg ? -x_reg : x_reg;
    assign s   = neg_reg ? -y_reg : y_reg;
    assign omc = (40'sd1 <<< 24) - c;

    // entry r,k: omc*ar*ak + sign*s*a_other*2^14, diag: c*2^28 + omc*ar*ar
    always_comb
    begin
        ai = ax; aj = ax; ak = ax; sgn = 1'b0; diag = 1'b0;
        unique case (ent_reg)
            4'd0: begin ai = ax; aj = ax; ak = ax; diag = 1'b1; end
            4'd1: begin ai = ax; aj = ay; ak = az; sgn = 1'b1; end
            4'd2: begin ai = ax; aj = az; ak = ay; end
            4'd3: begin ai = ay; aj = ax; ak = az; end
            4'd4: begin ai = ay; aj = ay; ak = ay; diag = 1'b1; end
            4'd5: begin ai = ay; aj = az; ak = ax; sgn = 1'b1; end
            4'd6: begin ai = az; aj = ax; ak = ay; sgn = 1'b1; end
            4'd7: begin ai = az; aj = ay; ak = ax; end
            4'd8: begin ai = az; aj = az; ak = az; diag = 1'b1; end
            default: begin ai = ax; aj = ax; ak = ax; end
        endcase
    end

    logic signed [57:0] pa_next, pb_next;
    logic signed [75:0] term, tsum;
    logic signed [75:0] rnd;
    logic signed [37:0] q14;
    logic signed [17:0] ent_val;
    logic [3:0]         ent_d_reg;
    logic               sgn_d_reg, diag_d_reg;
    logic signed [15:0] aj_d_reg;

    assign pa_next = 58'(omc) * 58'(ai);
    assign pb_next = diag ? 58'(c) * 58'sd16384 : 58'(s) * 58'(ak);

    always_comb
    begin
        term = 76'(pa_reg) * 76'(aj_d_reg);
        if (diag_d_reg)
            tsum = term + (76'(pb_reg) <<< 14);
        else if (sgn_d_reg)
            tsum = term - (76'(pb_reg) <<< 14);
        else
            tsum = term + (76'(pb_reg) <<< 14);
        rnd = (tsum + (76'sd1 <<< 37)) >>> 38;
        q14 = 38'(rnd);
        if (rnd > 76'(aapr_pkg::MAT_MAX))
            ent_val = aapr_pkg::MAT_MAX;
        else if (rnd < 76'(aapr_pkg::MAT_MIN))
            ent_val = aapr_pkg::MAT_MIN;
        else
            ent_val = q14[17:0];
    end

    // a start in any state (re)launches the build from the current registers
    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        ent_next = ent_reg;
        neg_next = neg_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (start)
        begin
            state_next = ST_CORD;
            step_next = 5'd0;
            x_next = aapr_pkg::CORDIC_GAIN;
            y_next = 40'sd0;
            z_next = 40'(ang_red) <<< 11;
            neg_next = (angle > aapr_pkg::HALF_PI_Q13)
                    || (angle < -aapr_pkg::HALF_PI_Q13);
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    state_next = ST_IDLE;
                ST_CORD:
                begin
                    if (z_reg >= 0)
                    begin
                        x_next = x_reg - (y_reg >>> step_reg);
                        y_next = y_reg + (x_reg >>> step_reg);
                        z_next = z_reg - aapr_pkg::atan_val(step_reg);
                    end
                    else
                    begin
                        x_next = x_reg + (y_reg >>> step_reg);
                        y_next = y_reg - (x_reg >>> step_reg);
                        z_next = z_reg + aapr_pkg::atan_val(step_reg);
                    end
                    step_next = step_reg + 5'd1;
                    if (step_reg == LAST_STEP)
                    begin
                        state_next = ST_MUL1;
                        ent_next = 4'd0;
                    end
                end
                ST_MUL1:
                begin
                    ent_next = ent_reg + 4'd1;
                    if (ent_reg == 4'd8)
                        state_next = ST_MUL2;
                end
                ST_MUL2:
                    state_next = ST_IDLE;
                default:
                    state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg <= 5'd0;
            ent_reg <= 4'd0;
            neg_reg <= 1'b0;
            wr_en_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            ent_reg <= ent_next;
            neg_reg <= neg_next;
            wr_en_reg <= (state_reg == ST_MUL2) || (state_reg == ST_MUL1 && ent_reg != 4'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        pa_reg <= pa_next;
        pb_reg <= pb_next;
        aj_d_reg <= aj;
        sgn_d_reg <= sgn;
        diag_d_reg <= diag;
        ent_d_reg <= ent_reg;
        wr_data_reg <= ent_val;
        wr_idx_reg <= ent_d_reg;
    end

    assign busy    = (state_reg != ST_IDLE) || wr_en_reg;
    assign wr_en   = wr_en_reg;
    assign wr_idx  = wr_idx_reg;
    assign wr_data = wr_data_reg;
endmodule
`default_nettype wire
